>>> rtl/lpp_pkg.sv
// Shared types and constants for the lidar point to pixel projection block.
`default_nettype none

package lpp_pkg;

  // Field widths of the request and result items.
  localparam int COEF_W    = 32;
  localparam int PT_W      = 20;
  localparam int CFG_W     = 19;
  localparam int CFG_DATA_W = 32;
  localparam int COEF_IDX_W = 4;
  localparam int COL_W     = 10;
  localparam int ROW_W     = 9;
  localparam int SHADE_W   = 8;
  localparam int NUM_COEFS = 12;

  // Internal arithmetic widths.
  localparam int PROD_W     = COEF_W + PT_W;      // coefficient times coordinate
  localparam int HOM_W      = PROD_W + 2;         // sum of three products and an offset
  localparam int SQ_W       = 2 * PT_W;           // sum of three squares
  localparam int RANGE_SQ_W = 2 * CFG_W;          // squared range limit
  localparam int SNUM_W     = CFG_W + SHADE_W;    // 255 times the shade distance

  // Shade scale.
  localparam logic [SHADE_W-1:0] SHADE_MAX = 8'd255;

  // Image defaults.
  localparam int DEF_IMAGE_WIDTH  = 640;
  localparam int DEF_IMAGE_HEIGHT = 480;

  // Register reset values.
  localparam logic [CFG_W-1:0] MIN_RANGE_RST  = 19'd0;
  localparam logic [CFG_W-1:0] MAX_RANGE_RST  = 19'd200000;
  localparam logic [CFG_W-1:0] COLOR_SPAN_RST = 19'd100000;

  // Request opcodes.
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_POINT = 1'b1
  } lpp_op_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_MIN_RANGE  = 2'd0,
    CFG_MAX_RANGE  = 2'd1,
    CFG_COLOR_SPAN = 2'd2
  } lpp_cfg_e;

  localparam int CFG_IDX_W = 2;

  // One request item.
  typedef struct packed {
    logic                     opcode;
    logic [COEF_IDX_W-1:0]    coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [PT_W-1:0]   point_x;
    logic signed [PT_W-1:0]   point_y;
    logic signed [PT_W-1:0]   point_z;
  } lpp_in_t;

  // One result item.
  typedef struct packed {
    logic                visible;
    logic [COL_W-1:0]    pixel_column;
    logic [ROW_W-1:0]    pixel_row;
    logic [SHADE_W-1:0]  shade_green;
    logic [SHADE_W-1:0]  shade_red;
  } lpp_out_t;

  // Control that travels with a point through the divider stages.
  typedef struct packed {
    logic vld;   // stage holds a point
    logic ok;    // all tests so far passed
    logic ge;    // shade distance is at least the span
  } lpp_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/lpp_div_pipe.sv
// Pipelined restoring dividers for pixel coordinates and the shade ratio.
`default_nettype none

module lpp_div_pipe #(
  parameter int QB = 10,
  parameter int ND = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire lpp_pkg::lpp_ctrl_t           ctrl_i,
  input  wire logic [lpp_pkg::HOM_W-1:0]    u_i,
  input  wire logic [lpp_pkg::HOM_W-1:0]    v_i,
  input  wire logic [lpp_pkg::HOM_W-1:0]    w_i,
  input  wire logic [lpp_pkg::SNUM_W-1:0]   snum_i,
  input  wire logic [lpp_pkg::CFG_W-1:0]    span_i,
  output lpp_pkg::lpp_ctrl_t                ctrl_o,
  output logic [QB-1:0]                     col_o,
  output logic [QB-1:0]                     row_o,
  output logic [lpp_pkg::SHADE_W-1:0]       shade_q_o,
  output logic                              shade_rem_nz_o
);

  localparam int DW = lpp_pkg::HOM_W + QB;
  localparam int SW = lpp_pkg::SNUM_W;
  localparam int HW = lpp_pkg::HOM_W;

  // Stage inputs (index 0 is the entry) and stage registers.
  lpp_pkg::lpp_ctrl_t        ctrl_s [ND+1];
  logic [DW-1:0]             ru_s   [ND+1];
  logic [DW-1:0]             rv_s   [ND+1];
  logic [QB-1:0]             qu_s   [ND+1];
  logic [QB-1:0]             qv_s   [ND+1];
  logic [HW-1:0]             w_s    [ND+1];
  logic [SW-1:0]             rs_s   [ND+1];
  logic [lpp_pkg::SHADE_W-1:0] qs_s [ND+1];
  logic [lpp_pkg::CFG_W-1:0] span_s [ND+1];

  lpp_pkg::lpp_ctrl_t        ctrl_q [ND];
  logic [DW-1:0]             ru_q   [ND];
  logic [DW-1:0]             rv_q   [ND];
  logic [QB-1:0]             qu_q   [ND];
  logic [QB-1:0]             qv_q   [ND];
  logic [HW-1:0]             w_q    [ND];
  logic [SW-1:0]             rs_q   [ND];
  logic [lpp_pkg::SHADE_W-1:0] qs_q [ND];
  logic [lpp_pkg::CFG_W-1:0] span_q [ND];

  // Entry of the chain.
  assign ctrl_s[0] = ctrl_i;
  assign ru_s[0]   = DW'(u_i);
  assign rv_s[0]   = DW'(v_i);
  assign qu_s[0]   = '0;
  assign qv_s[0]   = '0;
  assign w_s[0]    = w_i;
  assign rs_s[0]   = snum_i;
  assign qs_s[0]   = '0;
  assign span_s[0] = span_i;

  for (genvar k = 0; k < ND; k++) begin : g_stage
    logic [DW-1:0]               ru_d;
    logic [DW-1:0]               rv_d;
    logic [QB-1:0]               qu_d;
    logic [QB-1:0]               qv_d;
    logic [SW-1:0]               rs_d;
    logic [lpp_pkg::SHADE_W-1:0] qs_d;

    // One quotient bit of column and row per stage.
    if (k < QB) begin : g_pix
      localparam int BU = QB - 1 - k;
      logic [DW-1:0] wsh;
      always_comb begin
        wsh  = DW'(w_s[k]) << BU;
        ru_d = ru_s[k];
        rv_d = rv_s[k];
        qu_d = qu_s[k];
        qv_d = qv_s[k];
        if (ru_s[k] >= wsh) begin
          ru_d     = ru_s[k] - wsh;
          qu_d[BU] = 1'b1;
        end
        if (rv_s[k] >= wsh) begin
          rv_d     = rv_s[k] - wsh;
          qv_d[BU] = 1'b1;
        end
      end
    end else begin : g_pix_pass
      assign ru_d = ru_s[k];
      assign rv_d = rv_s[k];
      assign qu_d = qu_s[k];
      assign qv_d = qv_s[k];
    end

    // One quotient bit of the shade ratio per stage.
    if (k < lpp_pkg::SHADE_W) begin : g_shd
      localparam int BS = lpp_pkg::SHADE_W - 1 - k;
      logic [SW-1:0] ssh;
      always_comb begin
        ssh  = SW'(span_s[k]) << BS;
        rs_d = rs_s[k];
        qs_d = qs_s[k];
        if (rs_s[k] >= ssh) begin
          rs_d     = rs_s[k] - ssh;
          qs_d[BS] = 1'b1;
        end
      end
    end else begin : g_shd_pass
      assign rs_d = rs_s[k];
      assign qs_d = qs_s[k];
    end

    // Stage register.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_q[k] <= '0;
      end else if (en_i) begin
        ctrl_q[k] <= ctrl_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ru_q[k]   <= ru_d;
        rv_q[k]   <= rv_d;
        qu_q[k]   <= qu_d;
        qv_q[k]   <= qv_d;
        w_q[k]    <= w_s[k];
        rs_q[k]   <= rs_d;
        qs_q[k]   <= qs_d;
        span_q[k] <= span_s[k];
      end
    end

    assign ctrl_s[k+1] = ctrl_q[k];
    assign ru_s[k+1]   = ru_q[k];
    assign rv_s[k+1]   = rv_q[k];
    assign qu_s[k+1]   = qu_q[k];
    assign qv_s[k+1]   = qv_q[k];
    assign w_s[k+1]    = w_q[k];
    assign rs_s[k+1]   = rs_q[k];
    assign qs_s[k+1]   = qs_q[k];
    assign span_s[k+1] = span_q[k];
  end

  // Results of the last stage.
  assign ctrl_o         = ctrl_s[ND];
  assign col_o          = qu_s[ND];
  assign row_o          = qv_s[ND];
  assign shade_q_o      = qs_s[ND];
  assign shade_rem_nz_o = |rs_s[ND];

endmodule

`default_nettype wire

>>> rtl/lidar_point_to_pixel_projection.sv
// Top level of the lidar point to pixel projection pipeline.
//
// The block takes one request per clock. A load request writes one coefficient of the
// 3x4 projection matrix; it takes effect for every point request accepted after it and
// gives no result. A point request gives exactly one result, passing through an input
// stage, a product stage, a sum and range stage, one restoring divider stage per
// quotient bit of the pixel coordinates or of the shade ratio, whichever has more (the
// shade ratio runs alongside in the first eight), and the output register. Throughput
// is one point per cycle; only a stalled output holds the whole pipeline. Matrix
// entries must be written before any point uses them.
`default_nettype none

module lidar_point_to_pixel_projection #(
  parameter int IMAGE_WIDTH  = lpp_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = lpp_pkg::DEF_IMAGE_HEIGHT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire lpp_pkg::lpp_in_t                  in_req_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output lpp_pkg::lpp_out_t                      out_rsp_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [lpp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [lpp_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int IMG_MAX = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int QB      = $clog2(IMG_MAX);
  localparam int ND      = (QB > lpp_pkg::SHADE_W) ? QB : lpp_pkg::SHADE_W;
  localparam int HW      = lpp_pkg::HOM_W;
  localparam int PW      = lpp_pkg::PROD_W;
  localparam int DW      = HW + QB;

  // Pipeline advance: everything moves unless a finished result is held.
  logic adv;
  logic out_valid_q;
  lpp_pkg::lpp_out_t out_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  logic [lpp_pkg::CFG_W-1:0] min_range_q, max_range_q, color_span_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q  <= lpp_pkg::MIN_RANGE_RST;
      max_range_q  <= lpp_pkg::MAX_RANGE_RST;
      color_span_q <= lpp_pkg::COLOR_SPAN_RST;
    end else if (cfg_valid_i) begin
      unique case (lpp_pkg::lpp_cfg_e'(cfg_index_i))
        lpp_pkg::CFG_MIN_RANGE:  min_range_q  <= cfg_data_i[lpp_pkg::CFG_W-1:0];
        lpp_pkg::CFG_MAX_RANGE:  max_range_q  <= cfg_data_i[lpp_pkg::CFG_W-1:0];
        lpp_pkg::CFG_COLOR_SPAN: color_span_q <= cfg_data_i[lpp_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Squared range limits are registered from the registers, in the cycle after them.
  logic [lpp_pkg::RANGE_SQ_W-1:0] lo2_q, hi2_q;

  always_ff @(posedge clk_i) begin
    lo2_q <= min_range_q * min_range_q;
    hi2_q <= max_range_q * max_range_q;
  end

  // Stage 1: input register.
  logic             s1_vld_q;
  lpp_pkg::lpp_in_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= in_req_i;
    end
  end

  // Matrix store; a load writes it as it leaves stage 1, so earlier points are unaffected.
  logic signed [lpp_pkg::COEF_W-1:0] mat_q [lpp_pkg::NUM_COEFS];

  always_ff @(posedge clk_i) begin
    if (adv && s1_vld_q && (lpp_pkg::lpp_op_e'(s1_q.opcode) == lpp_pkg::OP_LOAD) &&
        (s1_q.coef_index < lpp_pkg::COEF_IDX_W'(lpp_pkg::NUM_COEFS))) begin
      mat_q[s1_q.coef_index] <= s1_q.coef_value;
    end
  end

  // Stage 1 products and squares.
  logic signed [PW-1:0]             prod_d [9];
  logic signed [lpp_pkg::SQ_W-1:0]  sqx_d, sqy_d, sqz_d;
  logic                             s1_pnt;

  assign s1_pnt = s1_vld_q && (lpp_pkg::lpp_op_e'(s1_q.opcode) == lpp_pkg::OP_POINT);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_d[r*3]   = mat_q[r*4]   * s1_q.point_x;
      prod_d[r*3+1] = mat_q[r*4+1] * s1_q.point_y;
      prod_d[r*3+2] = mat_q[r*4+2] * s1_q.point_z;
    end
    sqx_d = s1_q.point_x * s1_q.point_x;
    sqy_d = s1_q.point_y * s1_q.point_y;
    sqz_d = s1_q.point_z * s1_q.point_z;
  end

  // Stage 2 registers.
  logic                              s2_vld_q;
  logic signed [PW-1:0]              prod_q [9];
  logic signed [lpp_pkg::COEF_W-1:0] off_q [3];
  logic signed [lpp_pkg::SQ_W-1:0]   sqx_q, sqy_q, sqz_q;
  logic signed [lpp_pkg::PT_W-1:0]   s2_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_pnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q   <= prod_d;
      off_q[0] <= mat_q[3];
      off_q[1] <= mat_q[7];
      off_q[2] <= mat_q[11];
      sqx_q    <= sqx_d;
      sqy_q    <= sqy_d;
      sqz_q    <= sqz_d;
      s2_x_q   <= s1_q.point_x;
    end
  end

  // Stage 2: homogeneous sums, range test and shade distance.
  logic signed [HW-1:0]         hom_d [3];
  logic [lpp_pkg::SQ_W-1:0]     d2;
  logic                         range_ok;
  logic [lpp_pkg::CFG_W-1:0]    span_d, x19, diff_d;
  logic                         ge_d;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      hom_d[r] = HW'(prod_q[r*3]) + HW'(prod_q[r*3+1]) + HW'(prod_q[r*3+2]) +
                 HW'(off_q[r]);
    end
    d2       = unsigned'(sqx_q) + unsigned'(sqy_q) + unsigned'(sqz_q);
    range_ok = (lpp_pkg::SQ_W'(lo2_q) < d2) && (d2 < lpp_pkg::SQ_W'(hi2_q));
    // A zero span counts as one millimetre.
    span_d   = (color_span_q == '0) ? lpp_pkg::CFG_W'(1) : color_span_q;
    x19      = unsigned'(s2_x_q[lpp_pkg::CFG_W-1:0]);
    diff_d   = (x19 >= span_d) ? (x19 - span_d) : (span_d - x19);
    ge_d     = diff_d >= span_d;
  end

  // Stage 3 registers.
  logic                      s3_vld_q, s3_ok_q, s3_ge_q;
  logic signed [HW-1:0]      hom_q [3];
  logic [lpp_pkg::CFG_W-1:0] diff_q, span_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hom_q   <= hom_d;
      s3_ok_q <= !s2_x_q[lpp_pkg::PT_W-1] && range_ok;
      s3_ge_q <= ge_d;
      diff_q  <= diff_d;
      span_q  <= span_d;
    end
  end

  // Stage 3: depth and sign tests, pixel bound precheck, shade numerator.
  logic [HW-1:0]               u_uns, v_uns, w_uns;
  logic [DW-1:0]               wlim;
  logic                        hom_ok;
  logic [lpp_pkg::SNUM_W-1:0]  snum;
  lpp_pkg::lpp_ctrl_t          div_ctrl_in;

  always_comb begin
    u_uns  = unsigned'(hom_q[0]);
    v_uns  = unsigned'(hom_q[1]);
    w_uns  = unsigned'(hom_q[2]);
    wlim   = DW'(w_uns) << QB;
    // The quotient must fit the divider width; otherwise it lies outside the image.
    hom_ok = (hom_q[2] > 0) && (hom_q[0] >= 0) && (hom_q[1] >= 0) &&
             (DW'(u_uns) < wlim) && (DW'(v_uns) < wlim);
    snum   = (lpp_pkg::SNUM_W'(diff_q) << lpp_pkg::SHADE_W) - lpp_pkg::SNUM_W'(diff_q);
    div_ctrl_in.vld = s3_vld_q;
    div_ctrl_in.ok  = s3_ok_q && hom_ok;
    div_ctrl_in.ge  = s3_ge_q;
  end

  // Divider stages.
  lpp_pkg::lpp_ctrl_t            div_ctrl;
  logic [QB-1:0]                 col, row;
  logic [lpp_pkg::SHADE_W-1:0]   shade_q;
  logic                          shade_rem_nz;

  lpp_div_pipe #(
    .QB (QB),
    .ND (ND)
  ) u_div (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (adv),
    .ctrl_i         (div_ctrl_in),
    .u_i            (u_uns),
    .v_i            (v_uns),
    .w_i            (w_uns),
    .snum_i         (snum),
    .span_i         (span_q),
    .ctrl_o         (div_ctrl),
    .col_o          (col),
    .row_o          (row),
    .shade_q_o      (shade_q),
    .shade_rem_nz_o (shade_rem_nz)
  );

  // Final image bound test and shade values.
  lpp_pkg::lpp_out_t out_d;
  logic              vis;

  always_comb begin
    vis   = div_ctrl.ok &&
            ({1'b0, col} < (QB+1)'(IMAGE_WIDTH)) &&
            ({1'b0, row} < (QB+1)'(IMAGE_HEIGHT));
    out_d = '0;
    if (vis) begin
      out_d.visible      = 1'b1;
      out_d.pixel_column = lpp_pkg::COL_W'(col);
      out_d.pixel_row    = lpp_pkg::ROW_W'(row);
      if (div_ctrl.ge) begin
        out_d.shade_green = lpp_pkg::SHADE_MAX;
        out_d.shade_red   = '0;
      end else begin
        // Red is 255 minus the rounded-up ratio.
        out_d.shade_green = shade_q;
        out_d.shade_red   = lpp_pkg::SHADE_MAX - shade_q -
                            lpp_pkg::SHADE_W'(shade_rem_nz);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_ctrl.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

>>> rtl/lpp_checker.sv
// Port-level checks of the lidar point to pixel projection block and their binding.
`default_nettype none

module lpp_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire lpp_pkg::lpp_out_t              out_rsp_o
);

  logic [lpp_pkg::SHADE_W:0] shade_sum;
  assign shade_sum = {1'b0, out_rsp_o.shade_green} + {1'b0, out_rsp_o.shade_red};

  // A held result keeps its value until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("held result changed before it was taken");

  // Requests are refused only while a result waits for the consumer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request refused without output back pressure");

  // An invisible point carries all-zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.visible |->
      out_rsp_o.pixel_column == '0 && out_rsp_o.pixel_row == '0 &&
      out_rsp_o.shade_green == '0 && out_rsp_o.shade_red == '0)
    else $error("invisible point with nonzero fields");

  // Green and red of a visible point add to 254 or 255.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.visible |-> shade_sum == 9'd255 || shade_sum == 9'd254)
    else $error("shade components inconsistent");

endmodule

bind lidar_point_to_pixel_projection lpp_checker u_lpp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the lidar point to pixel projection block.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lpp_pkg::*;

  // Scoreboard: a private projection model and the queue of pending pixels.
  class pixel_scoreboard;
    logic signed [COEF_W-1:0] coefs[NUM_COEFS];
    logic [CFG_W-1:0] min_rng, max_rng, span_cfg;
    lpp_out_t pending_pixels[$];
    int errors;

    function new();
      for (int i = 0; i < NUM_COEFS; i++) coefs[i] = '0;
      min_rng = MIN_RANGE_RST;
      max_rng = MAX_RANGE_RST;
      span_cfg = COLOR_SPAN_RST;
      errors = 0;
    endfunction

    function void set_reg(lpp_cfg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MIN_RANGE:  min_rng = data[CFG_W-1:0];
        CFG_MAX_RANGE:  max_rng = data[CFG_W-1:0];
        CFG_COLOR_SPAN: span_cfg = data[CFG_W-1:0];
        default: ;
      endcase
    endfunction

    function longint row_sum(int r, longint x, longint y, longint z);
      return longint'(coefs[r*4]) * x + longint'(coefs[r*4+1]) * y
           + longint'(coefs[r*4+2]) * z + longint'(coefs[r*4+3]);
    endfunction

    // Notes an accepted request and predicts its pixel, if any.
    function void note_request(lpp_in_t req);
      longint x, y, z, u, v, w, d2, lo2, hi2, col, row, span, diff, green, red;
      lpp_out_t res;
      if (lpp_op_e'(req.opcode) == OP_LOAD) begin
        if (req.coef_index < NUM_COEFS) coefs[req.coef_index] = req.coef_value;
        return;
      end
      res = '0;
      x = req.point_x;
      y = req.point_y;
      z = req.point_z;
      lo2 = longint'(min_rng) * min_rng;
      hi2 = longint'(max_rng) * max_rng;
      d2 = x * x + y * y + z * z;
      if (x >= 0 && lo2 < d2 && d2 < hi2) begin
        u = row_sum(0, x, y, z);
        v = row_sum(1, x, y, z);
        w = row_sum(2, x, y, z);
        if (w > 0 && u >= 0 && v >= 0) begin
          col = u / w;
          row = v / w;
          if (col < 640 && row < 480) begin
            span = (span_cfg == 0) ? 1 : span_cfg;
            diff = (x >= span) ? x - span : span - x;
            green = (255 * diff) / span;
            if (green > 255) green = 255;
            red = (diff >= span) ? 0 : (255 * (span - diff)) / span;
            res.visible = 1'b1;
            res.pixel_column = col[COL_W-1:0];
            res.pixel_row = row[ROW_W-1:0];
            res.shade_green = green[SHADE_W-1:0];
            res.shade_red = red[SHADE_W-1:0];
          end
        end
      end
      pending_pixels.push_back(res);
    endfunction

    // Compares one result with the oldest pending pixel.
    function void check_result(lpp_out_t got);
      lpp_out_t exp_px;
      if (pending_pixels.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      exp_px = pending_pixels.pop_front();
      if (got.visible !== exp_px.visible) begin
        $error("visible: expected %0d actual %0d", exp_px.visible, got.visible); errors++;
      end
      if (got.pixel_column !== exp_px.pixel_column) begin
        $error("pixel_column: expected %0d actual %0d", exp_px.pixel_column,
               got.pixel_column); errors++;
      end
      if (got.pixel_row !== exp_px.pixel_row) begin
        $error("pixel_row: expected %0d actual %0d", exp_px.pixel_row, got.pixel_row);
        errors++;
      end
      if (got.shade_green !== exp_px.shade_green) begin
        $error("shade_green: expected %0d actual %0d", exp_px.shade_green,
               got.shade_green); errors++;
      end
      if (got.shade_red !== exp_px.shade_red) begin
        $error("shade_red: expected %0d actual %0d", exp_px.shade_red, got.shade_red);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = 14;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  lpp_in_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  lpp_out_t out_rsp_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  pixel_scoreboard sb = new();
  longint cycle_count = 0;
  bit stall_random = 1'b1;

  lidar_point_to_pixel_projection uut (.*);

  always #5 clk_i = ~clk_i;

  // Receiver: stalls in a pattern of its own, with stall-free stretches.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_rsp_o);
    if (!stall_random || cycle_count[9:8] == 2'b00) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(3) != 0);
  end

  // Sends one request and records it once accepted.
  task automatic send_request(lpp_in_t req);
    in_valid_i <= 1'b1;
    in_req_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req);
  endtask

  // With n of zero the task leaves valid untouched so the next request follows directly.
  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic load_coef(int idx, logic signed [COEF_W-1:0] val);
    lpp_in_t req;
    req = '0;
    req.opcode = OP_LOAD;
    req.coef_index = idx[COEF_IDX_W-1:0];
    req.coef_value = val;
    send_request(req);
  endtask

  task automatic send_point(logic signed [PT_W-1:0] x, logic signed [PT_W-1:0] y,
                            logic signed [PT_W-1:0] z);
    lpp_in_t req;
    req = '0;
    req.opcode = OP_POINT;
    req.coef_value = $urandom();
    req.coef_index = $urandom();
    req.point_x = x;
    req.point_y = y;
    req.point_z = z;
    send_request(req);
  endtask

  // A camera-like matrix: focal length f, principal point (cx, cy), depth along x.
  task automatic load_camera(int f, int cx, int cy);
    load_coef(0, 0);  load_coef(1, -f); load_coef(2, 0);  load_coef(3, $urandom_range(65535));
    load_coef(4, 0);  load_coef(5, 0);  load_coef(6, -f); load_coef(7, $urandom_range(65535));
    load_coef(8, 1);  load_coef(9, 0);  load_coef(10, 0); load_coef(11, $urandom_range(3));
    for (int i = 0; i < 3; i++) begin
      if (i == 0) load_coef(0, cx);
      if (i == 1) load_coef(4, cy);
    end
  endtask

  // Waits for all pending pixels, then for the pipeline to drain.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Writes one register; the caller drops valid after the last write.
  task automatic write_reg(lpp_cfg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  // Random point mostly near the camera's view, sometimes anywhere.
  task automatic random_point();
    logic signed [PT_W-1:0] x, y, z;
    if ($urandom_range(4) == 0) begin
      x = $urandom(); y = $urandom(); z = $urandom();
    end else begin
      x = $urandom_range(250000);
      y = $signed(x) / 2 - $signed(PT_W'($urandom_range(32'(x) + 1)));
      z = $signed(x) / 2 - $signed(PT_W'($urandom_range(32'(x) + 1)));
    end
    send_point(x, y, z);
  endtask

  int burst;
  int items;

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: every matrix entry written, then field extremes.
    for (int i = 0; i < NUM_COEFS; i++) load_coef(i, 0);
    load_coef(12, 32'h7fffffff);
    load_coef(15, 32'h80000000);
    send_point(20'sd1000, 0, 0);
    load_camera(300, 320, 240);
    send_point(0, 0, 0);
    send_point(20'sd5000, 0, 0);
    send_point(20'sd100000, 20'sd1000, -20'sd1000);
    send_point(20'sd199999, 0, 0);
    send_point(20'sd300000, 0, 0);
    send_point(-20'sd1, 0, 0);
    send_point(20'sh7ffff, 20'sh7ffff, 20'sh7ffff);
    send_point(20'sh80000, 20'sh80000, 20'sh80000);
    send_point(20'sd1000, 20'sd5000, 0);
    load_coef(8, -1);
    send_point(20'sd1000, 0, 0);
    load_coef(0, 32'h7fffffff);
    load_coef(1, 32'h80000000);
    send_point(20'sd1000, 20'sd7, 0);
    drain();

    // Random part through several register settings, extremes included.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_MIN_RANGE, 0); write_reg(CFG_MAX_RANGE, 19'h7ffff);
          write_reg(CFG_COLOR_SPAN, 1);
        end
        1: begin
          write_reg(CFG_MIN_RANGE, 19'h7ffff); write_reg(CFG_COLOR_SPAN, 19'h7ffff);
        end
        2: begin
          write_reg(CFG_MIN_RANGE, 1000); write_reg(CFG_MAX_RANGE, 150000);
          write_reg(CFG_COLOR_SPAN, 0);
        end
        3: write_reg(CFG_MAX_RANGE, 0);
        default: begin
          write_reg(CFG_MIN_RANGE, $urandom_range(5000));
          write_reg(CFG_MAX_RANGE, $urandom_range(524287, 100000));
          write_reg(CFG_COLOR_SPAN, $urandom_range(524287, 1));
          write_reg(lpp_cfg_e'(2'd3), $urandom());
        end
      endcase
      cfg_valid_i <= 1'b0;
      stall_random = (phase != 5);
      load_camera($urandom_range(1000, 1), $urandom_range(700), $urandom_range(520));
      items = 0;
      while (items < 220) begin
        burst = $urandom_range(20, 1);
        for (int b = 0; b < burst; b++) begin
          if ($urandom_range(30) == 0)
            load_coef($urandom_range(15), $urandom_range(3) == 0 ? $urandom() :
                      $urandom_range(65535));
          else random_point();
          items++;
        end
        if (phase != 5) idle_cycles($urandom_range(4));
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

`default_nettype wire
